### sv/wecs_pkg.sv
`default_nettype none

package wecs_pkg;

   // Sizing
   localparam int CHANNELS   = 32;
   localparam int HIST_DEPTH = 256;
   localparam int HIST_AW    = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
   localparam int LEN_W      = HIST_AW + 1;           // holds 1..HIST_DEPTH
   localparam int CFG_LEN_W  = 9;
   localparam int LEN_CMP_W  = (LEN_W > CFG_LEN_W) ? LEN_W : CFG_LEN_W;

   localparam int SCORE_W    = 7;
   localparam int CNT_W      = 6;
   localparam int SUM_W      = $clog2(3 * CHANNELS * HIST_DEPTH + 1);
   localparam int OUT_SUM_W  = 15;
   localparam int SUM_CMP_W  = (SUM_W > OUT_SUM_W) ? SUM_W : OUT_SUM_W;
   localparam int THR_W      = 9;
   localparam int THR_CMP_W  = (SUM_W > THR_W) ? SUM_W : THR_W;

   // Stream payloads
   localparam int IN_TDATA_W  = 72;
   localparam int OUT_TDATA_W = 56;

   // Register file
   localparam int CSR_DW    = 64;
   localparam int CSR_AW    = 6;
   localparam int REG_IDX_W = 3;

   localparam logic [REG_IDX_W-1:0] REG_LEVEL_ONE   = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_LEVEL_TWO   = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_LEVEL_THREE = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_CONFLUENCE  = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_LOOKBACK    = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_ARROW_WIN   = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_WEIGHTS     = 3'd6;
   localparam logic [REG_IDX_W-1:0] REG_GATE_EN     = 3'd7;

   typedef struct packed {
      logic [7:0]  level_one_threshold;
      logic [7:0]  level_two_threshold;
      logic [7:0]  level_three_threshold;
      logic [8:0]  confluence_threshold;
      logic [8:0]  lookback_bars;
      logic [8:0]  arrow_window_bars;
      logic [63:0] channel_weights;
      logic [3:0]  gate_enable_mask;
   } cfg_type;

   // Window length: zero means one bar, capped at the ring depth
   function automatic logic [LEN_W-1:0] clamp_len(input logic [CFG_LEN_W-1:0] n);
      logic [LEN_CMP_W-1:0] ext;
      ext = LEN_CMP_W'(n);
      if (n == '0) begin
         return LEN_W'(1);
      end
      if (ext > LEN_CMP_W'(HIST_DEPTH)) begin
         return LEN_W'(HIST_DEPTH);
      end
      return LEN_W'(ext);
   endfunction

   function automatic logic [OUT_SUM_W-1:0] sat_sum(input logic [SUM_W-1:0] s);
      logic [SUM_CMP_W-1:0] ext;
      ext = SUM_CMP_W'(s);
      if (ext > SUM_CMP_W'({OUT_SUM_W{1'b1}})) begin
         return {OUT_SUM_W{1'b1}};
      end
      return OUT_SUM_W'(ext);
   endfunction

   // Every enabled gate needs its flag set
   function automatic logic gates_pass(input logic [1:0] en, input logic [1:0] flags);
      return (en & ~flags) == 2'b00;
   endfunction

endpackage

`default_nettype wire

### sv/wecs_csr.sv
`default_nettype none

module wecs_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [wecs_pkg::CSR_AW-1:0]   csr_paddr,
   input  wire logic [wecs_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic      [wecs_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                               csr_pready,
   output wecs_pkg::cfg_type                  cfg,
   output logic                               hist_clear
);
   import wecs_pkg::*;

   cfg_type               cfg_ff;
   logic                  wr_en;
   logic [REG_IDX_W-1:0]  idx;

   assign csr_pready = 1'b1;
   assign idx        = csr_paddr[CSR_AW-1 -: REG_IDX_W];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign hist_clear = wr_en & ((idx == REG_LOOKBACK) | (idx == REG_ARROW_WIN));
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.level_one_threshold   <= 8'd3;
         cfg_ff.level_two_threshold   <= 8'd5;
         cfg_ff.level_three_threshold <= 8'd8;
         cfg_ff.confluence_threshold  <= 9'd6;
         cfg_ff.lookback_bars         <= 9'd5;
         cfg_ff.arrow_window_bars     <= 9'd1;
         cfg_ff.channel_weights       <= '0;
         cfg_ff.gate_enable_mask      <= '0;
      end else if (wr_en) begin
         case (idx)
            REG_LEVEL_ONE:   cfg_ff.level_one_threshold   <= csr_pwdata[7:0];
            REG_LEVEL_TWO:   cfg_ff.level_two_threshold   <= csr_pwdata[7:0];
            REG_LEVEL_THREE: cfg_ff.level_three_threshold <= csr_pwdata[7:0];
            REG_CONFLUENCE:  cfg_ff.confluence_threshold  <= csr_pwdata[8:0];
            REG_LOOKBACK:    cfg_ff.lookback_bars         <= csr_pwdata[8:0];
            REG_ARROW_WIN:   cfg_ff.arrow_window_bars     <= csr_pwdata[8:0];
            REG_WEIGHTS:     cfg_ff.channel_weights       <= csr_pwdata[63:0];
            REG_GATE_EN:     cfg_ff.gate_enable_mask      <= csr_pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_LEVEL_ONE:   csr_prdata = CSR_DW'(cfg_ff.level_one_threshold);
         REG_LEVEL_TWO:   csr_prdata = CSR_DW'(cfg_ff.level_two_threshold);
         REG_LEVEL_THREE: csr_prdata = CSR_DW'(cfg_ff.level_three_threshold);
         REG_CONFLUENCE:  csr_prdata = CSR_DW'(cfg_ff.confluence_threshold);
         REG_LOOKBACK:    csr_prdata = CSR_DW'(cfg_ff.lookback_bars);
         REG_ARROW_WIN:   csr_prdata = CSR_DW'(cfg_ff.arrow_window_bars);
         REG_WEIGHTS:     csr_prdata = CSR_DW'(cfg_ff.channel_weights);
         REG_GATE_EN:     csr_prdata = CSR_DW'(cfg_ff.gate_enable_mask);
         default:         csr_prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

### sv/wecs_edge_score.sv
`default_nettype none

module wecs_edge_score (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           push,
   input  wire logic [31:0]                    active,
   input  wire logic [31:0]                    present,
   input  wire logic [63:0]                    weights,
   output logic      [wecs_pkg::SCORE_W-1:0]   score,
   output logic      [wecs_pkg::CNT_W-1:0]     conn_count,
   output logic      [wecs_pkg::CNT_W-1:0]     edge_cnt
);
   import wecs_pkg::*;

   localparam int TREE_LVLS = $clog2(CHANNELS);
   localparam int TREE_N    = 1 << TREE_LVLS;

   logic [CHANNELS-1:0] prev_active_ff;
   logic [CHANNELS-1:0] prev_active_in;

   logic [SCORE_W-1:0] sc_t [TREE_LVLS+1][TREE_N];
   logic [CNT_W-1:0]   cn_t [TREE_LVLS+1][TREE_N];
   logic [CNT_W-1:0]   ed_t [TREE_LVLS+1][TREE_N];

   assign prev_active_in = active[CHANNELS-1:0] & present[CHANNELS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_active_ff <= '0;
      end else if (push) begin
         prev_active_ff <= prev_active_in;
      end
   end

   // Leaves per channel, then a pairwise adder tree
   always_comb begin
      logic [1:0] w;
      logic       used;
      logic       rise;
      for (int l = 0; l <= TREE_LVLS; l++) begin
         for (int i = 0; i < TREE_N; i++) begin
            sc_t[l][i] = '0;
            cn_t[l][i] = '0;
            ed_t[l][i] = '0;
         end
      end
      for (int c = 0; c < CHANNELS; c++) begin
         w    = weights[2*c +: 2];
         used = (w != 2'b00) & present[c];
         rise = used & active[c] & ~prev_active_ff[c];
         sc_t[0][c] = rise ? SCORE_W'(w) : '0;
         cn_t[0][c] = CNT_W'(used);
         ed_t[0][c] = CNT_W'(rise);
      end
      for (int l = 0; l < TREE_LVLS; l++) begin
         for (int i = 0; i < (TREE_N >> (l + 1)); i++) begin
            sc_t[l+1][i] = sc_t[l][2*i] + sc_t[l][2*i+1];
            cn_t[l+1][i] = cn_t[l][2*i] + cn_t[l][2*i+1];
            ed_t[l+1][i] = ed_t[l][2*i] + ed_t[l][2*i+1];
         end
      end
   end

   assign score      = sc_t[TREE_LVLS][0];
   assign conn_count = cn_t[TREE_LVLS][0];
   assign edge_cnt   = ed_t[TREE_LVLS][0];

endmodule

`default_nettype wire

### sv/wecs_history.sv
`default_nettype none

module wecs_history (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           clear,
   input  wire logic                           push,
   input  wire logic [wecs_pkg::SCORE_W-1:0]   score,
   input  wire logic [8:0]                     arrow_window_bars,
   input  wire logic [8:0]                     lookback_bars,
   output logic      [wecs_pkg::SCORE_W-1:0]   old_arrow,
   output logic      [wecs_pkg::SCORE_W-1:0]   old_lookback
);
   import wecs_pkg::*;

   logic [SCORE_W-1:0]  mem [HIST_DEPTH];
   logic [HIST_DEPTH-1:0] valid_ff;
   logic [HIST_AW-1:0]  ptr_ff;
   logic [HIST_AW-1:0]  ptr_in;
   logic [SCORE_W-1:0]  rd_a_ff;
   logic [SCORE_W-1:0]  rd_l_ff;
   logic                rd_va_ff;
   logic                rd_vl_ff;
   logic [LEN_W-1:0]    len_a;
   logic [LEN_W-1:0]    len_l;
   logic [LEN_W-1:0]    addr_a;
   logic [LEN_W-1:0]    addr_l;
   logic [LEN_W-1:0]    ptr_ext;

   assign len_a   = clamp_len(arrow_window_bars);
   assign len_l   = clamp_len(lookback_bars);
   assign ptr_ext = LEN_W'(ptr_ff);

   // Slot written len bars ago, modulo the ring depth
   assign addr_a = (ptr_ext >= len_a) ? ptr_ext - len_a
                                      : ptr_ext + LEN_W'(HIST_DEPTH) - len_a;
   assign addr_l = (ptr_ext >= len_l) ? ptr_ext - len_l
                                      : ptr_ext + LEN_W'(HIST_DEPTH) - len_l;

   assign ptr_in = (ptr_ff == HIST_AW'(HIST_DEPTH - 1)) ? '0 : ptr_ff + 1'b1;

   // Reads see the old contents, so a full-depth window reads the slot being replaced
   always_ff @(posedge clock) begin
      if (push) begin
         mem[ptr_ff] <= score;
         rd_a_ff     <= mem[addr_a[HIST_AW-1:0]];
         rd_l_ff     <= mem[addr_l[HIST_AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff <= '0;
         ptr_ff   <= '0;
         rd_va_ff <= 1'b0;
         rd_vl_ff <= 1'b0;
      end else if (push) begin
         rd_va_ff         <= valid_ff[addr_a[HIST_AW-1:0]];
         rd_vl_ff         <= valid_ff[addr_l[HIST_AW-1:0]];
         valid_ff[ptr_ff] <= 1'b1;
         ptr_ff           <= ptr_in;
      end
   end

   assign old_arrow    = rd_va_ff ? rd_a_ff : '0;
   assign old_lookback = rd_vl_ff ? rd_l_ff : '0;

endmodule

`default_nettype wire

### sv/wecs_window.sv
`default_nettype none

module wecs_window (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            clear,
   input  wire logic                            pop,
   input  wire wecs_pkg::cfg_type               cfg,
   input  wire logic [wecs_pkg::SCORE_W-1:0]    score,
   input  wire logic [wecs_pkg::SCORE_W-1:0]    old_arrow,
   input  wire logic [wecs_pkg::SCORE_W-1:0]    old_lookback,
   input  wire logic [1:0]                      arrow_gate_flags,
   input  wire logic [1:0]                      confluence_gate_flags,
   output logic      [wecs_pkg::OUT_SUM_W-1:0]  window_score,
   output logic      [wecs_pkg::OUT_SUM_W-1:0]  lookback_sum,
   output logic      [1:0]                      signal_level,
   output logic                                 confluence_flag
);
   import wecs_pkg::*;

   logic [SUM_W-1:0]     win_sum_ff;
   logic [SUM_W-1:0]     win_sum_in;
   logic [SUM_W-1:0]     lb_sum_ff;
   logic [SUM_W-1:0]     lb_sum_in;
   logic [THR_CMP_W-1:0] win_cmp;
   logic [THR_CMP_W-1:0] lb_cmp;

   assign win_sum_in = win_sum_ff + SUM_W'(score) - SUM_W'(old_arrow);
   assign lb_sum_in  = lb_sum_ff + SUM_W'(score) - SUM_W'(old_lookback);

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         win_sum_ff <= '0;
         lb_sum_ff  <= '0;
      end else if (pop) begin
         win_sum_ff <= win_sum_in;
         lb_sum_ff  <= lb_sum_in;
      end
   end

   assign win_cmp = THR_CMP_W'(win_sum_in);
   assign lb_cmp  = THR_CMP_W'(lb_sum_in);

   always_comb begin
      signal_level = 2'd0;
      if (gates_pass(cfg.gate_enable_mask[1:0], arrow_gate_flags)) begin
         if (win_cmp >= THR_CMP_W'(cfg.level_three_threshold)) begin
            signal_level = 2'd3;
         end else if (win_cmp >= THR_CMP_W'(cfg.level_two_threshold)) begin
            signal_level = 2'd2;
         end else if (win_cmp >= THR_CMP_W'(cfg.level_one_threshold)) begin
            signal_level = 2'd1;
         end
      end
   end

   assign confluence_flag = gates_pass(cfg.gate_enable_mask[3:2], confluence_gate_flags)
                            & (lb_cmp >= THR_CMP_W'(cfg.confluence_threshold));

   assign window_score = sat_sum(win_sum_in);
   assign lookback_sum = sat_sum(lb_sum_in);

endmodule

`default_nettype wire

### sv/weighted_edge_confluence_scorer_core.sv
`default_nettype none
// Path: input register, history read register, result register, then rsp_tvalid.
// Throughput: one item per cycle while rsp_tready does not stall;
//   the history ring does one write and two reads per item.
// Reset (synchronous, active high): registers to defaults, history ring empty,
//   running sums and previous-bar flags zero, pipeline empty. No clearing pass is needed.

module weighted_edge_confluence_scorer_core (
   input  wire logic                               clock,
   input  wire logic                               reset,

   // Bars in
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // [31:0] trigger_active, [63:32] trigger_present,
   // [65:64] arrow_gate_flags, [67:66] confluence_gate_flags, [71:68] zero
   input  wire logic [wecs_pkg::IN_TDATA_W-1:0]    req_tdata,

   // Scores out
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // [6:0] bar_score, [21:7] window_score, [36:22] lookback_sum,
   // [38:37] signal_level, [39] confluence_flag, [45:40] connected_count,
   // [51:46] edge_count, [55:52] zero
   output logic      [wecs_pkg::OUT_TDATA_W-1:0]   rsp_tdata,

   // Register port
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [wecs_pkg::CSR_AW-1:0]        csr_paddr,
   input  wire logic [wecs_pkg::CSR_DW-1:0]        csr_pwdata,
   output logic      [wecs_pkg::CSR_DW-1:0]        csr_prdata,
   output logic                                    csr_pready
);
   import wecs_pkg::*;

   cfg_type cfg;
   logic    hist_clear;

   // Three-stage pipe with per-stage enables; bubbles collapse under backpressure.
   logic a_valid_ff, b_valid_ff, rsp_valid_ff;
   logic a_en, b_en, out_en;
   logic push;   // item moves from input register to history stage
   logic pop;    // item moves from history stage to result register

   // Stage A: registered input item
   logic [31:0] a_active_ff;
   logic [31:0] a_present_ff;
   logic [1:0]  a_agate_ff;
   logic [1:0]  a_cgate_ff;

   // Stage B: score and counts, history read data in flight
   logic [SCORE_W-1:0] b_score_ff;
   logic [CNT_W-1:0]   b_conn_ff;
   logic [CNT_W-1:0]   b_edge_ff;
   logic [1:0]         b_agate_ff;
   logic [1:0]         b_cgate_ff;

   logic [SCORE_W-1:0] score;
   logic [CNT_W-1:0]   conn_count;
   logic [CNT_W-1:0]   edge_cnt;
   logic [SCORE_W-1:0] old_arrow;
   logic [SCORE_W-1:0] old_lookback;

   logic [OUT_SUM_W-1:0] window_score;
   logic [OUT_SUM_W-1:0] lookback_sum;
   logic [1:0]           signal_level;
   logic                 confluence_flag;

   logic [OUT_TDATA_W-1:0] rsp_tdata_ff;
   logic [OUT_TDATA_W-1:0] rsp_tdata_in;

   assign out_en     = ~rsp_valid_ff | rsp_tready;
   assign b_en       = ~b_valid_ff | out_en;
   assign a_en       = ~a_valid_ff | b_en;
   assign req_tready = a_en;
   assign push       = a_valid_ff & b_en;
   assign pop        = b_valid_ff & out_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (a_en) begin
            a_valid_ff <= req_tvalid;
         end
         if (b_en) begin
            b_valid_ff <= a_valid_ff;
         end
         if (out_en) begin
            rsp_valid_ff <= b_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && a_en) begin
         a_active_ff  <= req_tdata[31:0];
         a_present_ff <= req_tdata[63:32];
         a_agate_ff   <= req_tdata[65:64];
         a_cgate_ff   <= req_tdata[67:66];
      end
      if (push) begin
         b_score_ff <= score;
         b_conn_ff  <= conn_count;
         b_edge_ff  <= edge_cnt;
         b_agate_ff <= a_agate_ff;
         b_cgate_ff <= a_cgate_ff;
      end
      if (pop) begin
         rsp_tdata_ff <= rsp_tdata_in;
      end
   end

   wecs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg),
      .hist_clear  (hist_clear)
   );

   // Rising-edge detect and weighted adder tree; previous-bar flags update on push
   wecs_edge_score u_edge (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .active     (a_active_ff),
      .present    (a_present_ff),
      .weights    (cfg.channel_weights),
      .score      (score),
      .conn_count (conn_count),
      .edge_cnt   (edge_cnt)
   );

   // Ring of bar scores; reads of the oldest in-window entries land in stage B
   wecs_history u_hist (
      .clock             (clock),
      .reset             (reset),
      .clear             (hist_clear),
      .push              (push),
      .score             (score),
      .arrow_window_bars (cfg.arrow_window_bars),
      .lookback_bars     (cfg.lookback_bars),
      .old_arrow         (old_arrow),
      .old_lookback      (old_lookback)
   );

   // Running sums, level classification and confluence test
   wecs_window u_win (
      .clock                 (clock),
      .reset                 (reset),
      .clear                 (hist_clear),
      .pop                   (pop),
      .cfg                   (cfg),
      .score                 (b_score_ff),
      .old_arrow             (old_arrow),
      .old_lookback          (old_lookback),
      .arrow_gate_flags      (b_agate_ff),
      .confluence_gate_flags (b_cgate_ff),
      .window_score          (window_score),
      .lookback_sum          (lookback_sum),
      .signal_level          (signal_level),
      .confluence_flag       (confluence_flag)
   );

   assign rsp_tdata_in = {4'b0000, b_edge_ff, b_conn_ff, confluence_flag, signal_level,
                          lookback_sum, window_score, b_score_ff};

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

`default_nettype wire

### bench/tb_weighted_edge_confluence_scorer_core.sv
`default_nettype none

module tb_weighted_edge_confluence_scorer_core;
   import wecs_pkg::*;

   // ~1900 items with the largest sender and receiver idle draws stay far below this
   localparam int CYCLE_LIMIT = 500000;
   localparam int SUM_CAP     = 32767;

   // One bar as it sits in req_tdata, trigger_active in the low bits
   typedef struct packed {
      logic [1:0]          confluence_gate_flags;
      logic [1:0]          arrow_gate_flags;
      logic [CHANNELS-1:0] trigger_present;
      logic [CHANNELS-1:0] trigger_active;
   } bar_type;

   // One score item as it sits in rsp_tdata, bar_score in the low bits
   typedef struct packed {
      logic [3:0]  pad;
      logic [5:0]  edge_count;
      logic [5:0]  connected_count;
      logic        confluence_flag;
      logic [1:0]  signal_level;
      logic [14:0] lookback_sum;
      logic [14:0] window_score;
      logic [6:0]  bar_score;
   } score_type;

   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [IN_TDATA_W-1:0]   req_tdata;
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [OUT_TDATA_W-1:0]  rsp_tdata;
   logic                    csr_psel;
   logic                    csr_penable;
   logic                    csr_pwrite;
   logic [CSR_AW-1:0]       csr_paddr;
   logic [CSR_DW-1:0]       csr_pwdata;
   logic [CSR_DW-1:0]       csr_prdata;
   logic                    csr_pready;

   weighted_edge_confluence_scorer_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // ---------------------------------------------------------------
   // Scoring model state: registers, previous-bar flags, score ring
   // ---------------------------------------------------------------
   cfg_type              scorer_cfg;
   logic [CHANNELS-1:0]  prev_active;
   logic [SCORE_W-1:0]   score_ring [HIST_DEPTH];
   int                   ring_ptr;
   int                   arrow_sum;
   int                   lookback_total;

   score_type            pending_scores[$];   // expected score items, oldest first
   int                   error_count;
   int                   cycle_count;
   int                   send_gap_max;        // sender idle draw 0..max per item
   int                   ready_stall_max;     // receiver stall draw 0..max per item
   logic [CHANNELS-1:0]  last_sent_active;    // random bars toggle from this

   // ---------------------------------------------------------------
   // Clock and cycle limit
   // ---------------------------------------------------------------
   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Model
   // ---------------------------------------------------------------
   function automatic void clear_ring();
      for (int i = 0; i < HIST_DEPTH; i++) begin
         score_ring[HIST_AW'(i)] = '0;
      end
      ring_ptr       = 0;
      arrow_sum      = 0;
      lookback_total = 0;
   endfunction

   function automatic void model_reset();
      scorer_cfg.level_one_threshold   = 8'd3;
      scorer_cfg.level_two_threshold   = 8'd5;
      scorer_cfg.level_three_threshold = 8'd8;
      scorer_cfg.confluence_threshold  = 9'd6;
      scorer_cfg.lookback_bars         = 9'd5;
      scorer_cfg.arrow_window_bars     = 9'd1;
      scorer_cfg.channel_weights       = '0;
      scorer_cfg.gate_enable_mask      = '0;
      prev_active = '0;
      clear_ring();
   endfunction

   // Zero length means one bar; longer than the ring means the whole ring
   function automatic int bars_in_window(input logic [8:0] n);
      if (n == 0) begin
         return 1;
      end
      if (int'(n) > HIST_DEPTH) begin
         return HIST_DEPTH;
      end
      return int'(n);
   endfunction

   function automatic void apply_reg(input logic [REG_IDX_W-1:0] idx,
                                     input logic [63:0] value);
      case (idx)
         REG_LEVEL_ONE:   scorer_cfg.level_one_threshold   = value[7:0];
         REG_LEVEL_TWO:   scorer_cfg.level_two_threshold   = value[7:0];
         REG_LEVEL_THREE: scorer_cfg.level_three_threshold = value[7:0];
         REG_CONFLUENCE:  scorer_cfg.confluence_threshold  = value[8:0];
         REG_LOOKBACK: begin
            scorer_cfg.lookback_bars = value[8:0];
            clear_ring();
         end
         REG_ARROW_WIN: begin
            scorer_cfg.arrow_window_bars = value[8:0];
            clear_ring();
         end
         REG_WEIGHTS:     scorer_cfg.channel_weights  = value;
         REG_GATE_EN:     scorer_cfg.gate_enable_mask = value[3:0];
         default: ;
      endcase
   endfunction

   // Scores one bar and advances the model by one bar
   function automatic score_type score_bar(input bar_type b);
      score_type  r;
      logic [1:0] w;
      int         total, conn, rises, aw, lb, old_a, old_l, level;
      logic       conf;
      total = 0;
      conn  = 0;
      rises = 0;
      for (int c = 0; c < CHANNELS; c++) begin
         w = scorer_cfg.channel_weights[2*c +: 2];
         if (w != 2'd0 && b.trigger_present[c]) begin
            conn++;
            if (b.trigger_active[c] && !prev_active[c]) begin
               total += int'(w);
               rises++;
            end
         end
      end
      // absent channels are recorded as inactive
      prev_active = b.trigger_active & b.trigger_present;

      aw    = bars_in_window(scorer_cfg.arrow_window_bars);
      lb    = bars_in_window(scorer_cfg.lookback_bars);
      old_a = int'(score_ring[HIST_AW'((ring_ptr + HIST_DEPTH - aw) % HIST_DEPTH)]);
      old_l = int'(score_ring[HIST_AW'((ring_ptr + HIST_DEPTH - lb) % HIST_DEPTH)]);
      arrow_sum      = arrow_sum + total - old_a;
      lookback_total = lookback_total + total - old_l;
      score_ring[HIST_AW'(ring_ptr)] = SCORE_W'(total);
      ring_ptr = (ring_ptr + 1) % HIST_DEPTH;

      level = 0;
      if ((scorer_cfg.gate_enable_mask[1:0] & ~b.arrow_gate_flags) == 2'b00) begin
         if (arrow_sum >= int'(scorer_cfg.level_three_threshold)) begin
            level = 3;
         end else if (arrow_sum >= int'(scorer_cfg.level_two_threshold)) begin
            level = 2;
         end else if (arrow_sum >= int'(scorer_cfg.level_one_threshold)) begin
            level = 1;
         end
      end
      conf = ((scorer_cfg.gate_enable_mask[3:2] & ~b.confluence_gate_flags) == 2'b00) &&
             (lookback_total >= int'(scorer_cfg.confluence_threshold));

      r                 = '0;
      r.bar_score       = 7'(total);
      r.window_score    = 15'((arrow_sum > SUM_CAP) ? SUM_CAP : arrow_sum);
      r.lookback_sum    = 15'((lookback_total > SUM_CAP) ? SUM_CAP : lookback_total);
      r.signal_level    = 2'(level);
      r.confluence_flag = conf;
      r.connected_count = 6'(conn);
      r.edge_count      = 6'(rises);
      return r;
   endfunction

   // ---------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------
   function automatic bar_type make_bar(input logic [31:0] active, input logic [31:0] present,
                                        input logic [1:0] agates, input logic [1:0] cgates);
      bar_type b;
      b.trigger_active        = active;
      b.trigger_present       = present;
      b.arrow_gate_flags      = agates;
      b.confluence_gate_flags = cgates;
      return b;
   endfunction

   // Mostly toggles a few channels of the last bar so edges stay frequent but not total;
   // channels are mostly present, sometimes a random subset
   function automatic bar_type random_bar();
      bar_type b;
      if ($urandom_range(0, 3) == 0) begin
         b.trigger_active = $urandom();
      end else begin
         b.trigger_active = last_sent_active ^ ($urandom() & $urandom());
      end
      case ($urandom_range(0, 7))
         0:       b.trigger_present = $urandom();
         1:       b.trigger_present = ~($urandom() & $urandom() & $urandom());
         default: b.trigger_present = '1;
      endcase
      b.arrow_gate_flags      = 2'($urandom_range(0, 3));
      b.confluence_gate_flags = 2'($urandom_range(0, 3));
      return b;
   endfunction

   // Called at a rising edge; returns at the edge that takes the item
   task automatic send_bar(input bar_type b);
      int gap;
      gap = $urandom_range(0, send_gap_max);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= IN_TDATA_W'(b);
      req_tvalid <= 1'b1;
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
      last_sent_active = b.trigger_active;
      pending_scores.push_back(score_bar(b));
   endtask

   task automatic send_random_bars(input int count);
      for (int i = 0; i < count; i++) begin
         send_bar(random_bar());
      end
   endtask

   // Sender stops and waits until every score is back, plus pipeline slack
   task automatic wait_quiet();
      req_tvalid <= 1'b0;
      while (pending_scores.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Register writes only happen with the block drained
   task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [63:0] value);
      wait_quiet();
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= CSR_AW'({idx, 3'b000});
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(negedge clock); while (!csr_pready);
      @(posedge clock);
      apply_reg(idx, value);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic program_config(input int l1, input int l2, input int l3, input int conf,
                                 input int lookback, input int arrow_win,
                                 input logic [63:0] weights, input logic [3:0] gates);
      write_reg(REG_LEVEL_ONE,   64'(l1));
      write_reg(REG_LEVEL_TWO,   64'(l2));
      write_reg(REG_LEVEL_THREE, 64'(l3));
      write_reg(REG_CONFLUENCE,  64'(conf));
      write_reg(REG_LOOKBACK,    64'(lookback));
      write_reg(REG_ARROW_WIN,   64'(arrow_win));
      write_reg(REG_WEIGHTS,     weights);
      write_reg(REG_GATE_EN,     64'(gates));
   endtask

   function automatic logic [63:0] random_weights();
      case ($urandom_range(0, 3))
         0:       return {$urandom() & $urandom(), $urandom() & $urandom()};
         1:       return {32'h5555_5555, 32'h5555_5555} | {$urandom(), $urandom()};
         default: return {$urandom(), $urandom()};
      endcase
   endfunction

   function automatic int urandom_gate_mask();
      return $urandom_range(0, 15);
   endfunction

   // ---------------------------------------------------------------
   // Score receiver and checker
   // ---------------------------------------------------------------
   function automatic void check_field(input string name, input int expected, input int actual);
      if (expected != actual) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expected, actual);
         error_count++;
      end
   endfunction

   initial begin
      score_type got, want;
      int        stall;
      rsp_tready = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         stall = $urandom_range(0, ready_stall_max);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(negedge clock); while (rsp_tvalid !== 1'b1);
         got = score_type'(rsp_tdata);
         @(posedge clock);
         if (pending_scores.size() == 0) begin
            $display("%0t: score item with none expected, expected none, actual %h",
                     $time, got);
            error_count++;
         end else begin
            want = pending_scores.pop_front();
            check_field("bar_score",       int'(want.bar_score),       int'(got.bar_score));
            check_field("window_score",    int'(want.window_score),    int'(got.window_score));
            check_field("lookback_sum",    int'(want.lookback_sum),    int'(got.lookback_sum));
            check_field("signal_level",    int'(want.signal_level),    int'(got.signal_level));
            check_field("confluence_flag", int'(want.confluence_flag),
                        int'(got.confluence_flag));
            check_field("connected_count", int'(want.connected_count),
                        int'(got.connected_count));
            check_field("edge_count",      int'(want.edge_count),      int'(got.edge_count));
            check_field("tdata padding",   int'(want.pad),             int'(got.pad));
         end
      end
   end

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------

   // Reset values: all weights zero, so nothing connects or scores
   task automatic test_reset_defaults();
      send_random_bars(4);
   endtask

   task automatic test_directed_edges();
      program_config(3, 5, 8, 6, 5, 1, '1, 4'h0);
      send_bar(make_bar('1, '1, 2'd0, 2'd0));              // first bar: every channel not active before rises
      send_bar(make_bar('1, '1, 2'd3, 2'd3));              // held high: no edges
      send_bar(make_bar('0, '1, 2'd0, 2'd0));
      send_bar(make_bar('1, '0, 2'd0, 2'd0));              // all absent
      send_bar(make_bar('1, '1, 2'd0, 2'd0));              // absent bar counted as inactive
      send_bar(make_bar(32'hAAAA_AAAA, '1, 2'd1, 2'd2));
      send_bar(make_bar(32'h5555_5555, '1, 2'd2, 2'd1));
      send_bar(make_bar('1, 32'h0000_FFFF, 2'd0, 2'd0));
      // weights alternate 0 and 1 per channel
      write_reg(REG_WEIGHTS, {16{4'hE}} ^ {32{2'b10}});
      send_bar(make_bar('0, '1, 2'd0, 2'd0));
      send_bar(make_bar('1, '1, 2'd0, 2'd0));
      // all gates enabled: only flags 3 pass
      write_reg(REG_GATE_EN, 64'hF);
      send_bar(make_bar('0, '1, 2'd0, 2'd0));
      send_bar(make_bar('1, '1, 2'd1, 2'd2));
      send_bar(make_bar('0, '1, 2'd2, 2'd1));
      send_bar(make_bar('1, '1, 2'd3, 2'd3));
      // one gate of each kind enabled
      write_reg(REG_GATE_EN, 64'h5);
      send_bar(make_bar('0, '1, 2'd1, 2'd1));
      send_bar(make_bar('1, '1, 2'd2, 2'd2));
      // zero thresholds are always reached, max thresholds never
      program_config(0, 0, 0, 0, 5, 1, '1, 4'h0);
      send_bar(make_bar('0, '0, 2'd0, 2'd0));
      write_reg(REG_LEVEL_ONE, 64'd255);
      write_reg(REG_LEVEL_TWO, 64'd255);
      write_reg(REG_LEVEL_THREE, 64'd255);
      write_reg(REG_CONFLUENCE, 64'd511);
      send_bar(make_bar('1, '1, 2'd0, 2'd0));
      // rewriting a window register with its own value still clears history
      write_reg(REG_LOOKBACK, 64'd5);
      send_bar(make_bar('0, '1, 2'd0, 2'd0));
      send_bar(make_bar('1, '1, 2'd0, 2'd0));
   endtask

   // Window lengths zero, full ring, beyond the ring; threshold extremes
   task automatic test_window_extremes();
      program_config(0, 0, 0, 0, 256, 0, random_weights(), 4'(urandom_gate_mask()));
      send_random_bars(120);
      program_config(255, 255, 255, 511, 0, 256, random_weights(), 4'h0);
      send_random_bars(350);                               // wraps the ring
      program_config(150, 200, 255, 450, 511, 300, '1, 4'(urandom_gate_mask()));
      send_random_bars(150);
      program_config(1, 2, 3, 1, 1, 1, random_weights(), 4'(urandom_gate_mask()));
      send_random_bars(80);
   endtask

   // Short random windows with thresholds near the sums they produce
   task automatic test_random_settings();
      int l1, l2, l3, aw, lb;
      for (int phase = 0; phase < 6; phase++) begin
         aw = $urandom_range(1, 8);
         lb = $urandom_range(1, 12);
         l1 = $urandom_range(0, 20);
         l2 = l1 + $urandom_range(0, 25);
         l3 = l2 + $urandom_range(0, 40);
         program_config(l1, l2, l3, $urandom_range(0, 80), lb, aw,
                        random_weights(), 4'(urandom_gate_mask()));
         case (phase)
            1: begin                                      // back to back, no idling
               send_gap_max    = 0;
               ready_stall_max = 0;
            end
            3: begin                                      // receiver-bound
               send_gap_max    = 0;
               ready_stall_max = 13;
            end
            default: begin
               send_gap_max    = 13;
               ready_stall_max = 13;
            end
         endcase
         if (phase == 2) begin
            send_random_bars(110);
            wait_quiet();                                 // sender holds until all scores are back
            send_random_bars(80);
         end else if (phase == 4) begin
            send_random_bars(95);
            write_reg(REG_LOOKBACK, 64'(lb));
            send_random_bars(95);
         end else begin
            send_random_bars(190);
         end
      end
      send_gap_max    = 13;
      ready_stall_max = 13;
   endtask

   // ---------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------
   initial begin
      reset            = 1'b1;
      req_tvalid       = 1'b0;
      req_tdata        = '0;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = '0;
      csr_pwdata       = '0;
      error_count      = 0;
      cycle_count      = 0;
      send_gap_max     = 13;
      ready_stall_max  = 13;
      last_sent_active = '0;
      model_reset();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_directed_edges();
      test_window_extremes();
      test_random_settings();

      wait_quiet();
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

`default_nettype wire
